/* rtl/core/isort_pkg.sv */
package isort_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [31:0] t_word;
    typedef logic [CNT_W-1:0]   t_count;

    typedef struct packed {
        t_word value;
        logic  is_last;
    } t_in_item;

    typedef struct packed {
        t_word sorted_value;
        logic  end_of_set;
        logic  overflow;
    } t_out_item;

    // what one cell shows its upper neighbour
    typedef struct packed {
        logic  occ;
        logic  gt;
        t_word val;
    } t_link;

    // row-wide command, the same for every cell
    typedef struct packed {
        logic  ins;
        logic  unload;
        t_word word;
    } t_cell_ctrl;

endpackage

/* rtl/core/isort_cell.sv */
module isort_cell
    import isort_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occ,
    input  t_link      i_lower,
    input  t_word      i_upper_val,
    output t_link      o_link
);

    t_word r_val;
    t_word n_val;
    logic  gt;

    assign gt     = i_occ && (r_val > i_ctrl.word);
    assign o_link = '{occ: i_occ, gt: gt, val: r_val};

    always_comb begin
        n_val = r_val;
        if (i_ctrl.unload) begin
            n_val = i_upper_val;
        end else if (i_ctrl.ins) begin
            // larger entries move up; the new word lands above all entries not greater
            if (gt || (!i_occ && i_lower.occ)) begin
                n_val = i_lower.gt ? i_lower.val : i_ctrl.word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* rtl/core/insertion_sort_engine_top.sv */
// streaming insertion sort of signed 32-bit words
// input: raise start with a word on i_item; it is taken at the clock edge
//   where start is high and busy is low. each word is inserted in parallel
//   by a row of CAPACITY compare-and-shift cells, so words marked not last
//   may follow back to back, one per cycle.
// a word marked is_last is inserted, then the row is emptied from its lowest
//   cell, one word per cycle, ascending. busy stays high until the last
//   stored word has left the row, so the next set starts after that unload.
// output: o_valid marks each result for exactly one cycle; a word is registered
//   as it leaves the lowest cell, so the first result reaches the ports only
//   after busy is raised and the result register is then loaded from that cell.
//   end_of_set marks the final result of a set, overflow is set on
//   every result of a set that lost words to a full row.
// words beyond CAPACITY are dropped; the stored set is left untouched.
// the receiver cannot stall: results are shown once and not held.
// reset (synchronous, active low) empties the row and clears the drop flag;
//   cell contents are not cleared, the count alone says which are in use.
module insertion_sort_engine_top
    import isort_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    t_count     r_count;
    t_count     n_count;
    logic       r_drop;
    logic       n_drop;
    logic       r_unload;
    logic       n_unload;
    logic       r_valid;
    t_out_item  r_result;
    logic       accept;
    logic       full;
    t_cell_ctrl ctrl;
    t_link      links [CAPACITY];

    assign busy   = r_unload;
    assign accept = start && !r_unload;
    assign full   = (r_count == t_count'(CAPACITY));

    assign ctrl = '{ins: accept && !full, unload: r_unload, word: i_item.value};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link lower;
        t_word upper_val;
        if (g == 0) begin : g_first
            assign lower = '{occ: 1'b1, gt: 1'b0, val: '0};
        end else begin : g_mid
            assign lower = links[g-1];
        end
        if (g == CAPACITY - 1) begin : g_top
            assign upper_val = '0;
        end else begin : g_below
            assign upper_val = links[g+1].val;
        end
        isort_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_occ       (t_count'(g) < r_count),
            .i_lower     (lower),
            .i_upper_val (upper_val),
            .o_link      (links[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_drop   = r_drop;
        n_unload = r_unload;
        if (r_unload) begin
            n_count = r_count - t_count'(1);
            if (r_count == t_count'(1)) begin
                n_unload = 1'b0;
                n_drop   = 1'b0;
            end
        end else if (accept) begin
            if (full) begin
                n_drop = 1'b1;
            end else begin
                n_count = r_count + t_count'(1);
            end
            if (i_item.is_last) begin
                if (n_count != '0) begin
                    n_unload = 1'b1;
                end else begin
                    n_drop = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_unload <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_unload <= n_unload;
            r_valid  <= r_unload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_unload) begin
            r_result <= '{sorted_value: links[0].val,
                          end_of_set:   (r_count == t_count'(1)),
                          overflow:     r_drop};
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
